/* rtl/swap_slot_allocator_core_defines.svh */
// Assertion macros shared by the swap slot allocator RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef SWAP_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define SWAP_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ssa_pkg.sv */
// Types, codes and sizing constants for the swap slot allocator.
// Depends on nothing; used by the top level and the bench, not by ssa_ram.
`timescale 1ns / 1ps

package ssa_pkg;

  // Sizing of the slot map and the page geometry.
  localparam int unsigned SLOTS        = 1024;
  localparam int unsigned PAGE_SECTORS = 8;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned SECTOR_BYTES = 512;

  // The free map is held as words of WORD_BITS slots each.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned ROWS      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CNT_W     = (PAGE_SECTORS > 1) ? $clog2(PAGE_SECTORS) : 1;

  // Field widths.
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned SECTOR_W = 13;
  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CFG_W    = 11;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_SLOTS_PRESENT = 1'b0;  // register index, from paddr[2]
  localparam logic [CFG_W-1:0] SLOTS_PRESENT_RESET = CFG_W'(1024);

  // Operation codes; the last one is unused and produces nothing.
  localparam logic [1:0] OP_SWAP_OUT = 2'd0;
  localparam logic [1:0] OP_SWAP_IN  = 2'd1;
  localparam logic [1:0] OP_FREE     = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Command kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_UNUSED   = 2'd2;
  localparam logic [1:0] STAT_RANGE    = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [SLOT_W-1:0]  slot_index;
    logic [FRAME_W-1:0] frame_number;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_number;
    logic [SECTOR_W-1:0] sector_number;
    logic [ADDR_W-1:0]   memory_address;
    logic [1:0]          command_kind;
    logic [1:0]          status;
    logic                last;
  } result_t;

  // Position of the lowest set bit of a word; zero when the word is empty.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* rtl/ssa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the slot free map for the allocator.
`timescale 1ns / 1ps

module ssa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/swap_slot_allocator_core.sv */
// Top level of the swap slot allocator: command port, sequencer and free map.
// Depends on ssa_pkg, ssa_ram and swap_slot_allocator_core_defines.svh.
`timescale 1ns / 1ps
`include "swap_slot_allocator_core_defines.svh"

// A command is taken when start_i is high and busy_o is low. Results come out
// one per cycle on result_o, marked by result_valid_o; the receiver cannot
// stall them, and the final result of a command has last set. The free map is
// one RAM word of 32 slots per row, and a single read port scans one word per
// cycle, so a swap-out scans upward from word 0 until it finds a free slot and
// then emits 8 sector commands. A swap-out that finds no free slot scans every
// word that holds a usable slot, at least one, before it reports the full status.
// A swap-in also emits 8 sector commands; a free, an unassigned slot or a bad
// index gives a single status result, and an unused opcode gives no result.
// Rows of the map that were never written read as all free, so the map is
// usable directly after reset with no clearing pass.
module swap_slot_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel.
  input  logic                          start_i,
  output logic                          busy_o,
  input  ssa_pkg::cmd_t                 cmd_i,
  // Result channel.
  output logic                          result_valid_o,
  output ssa_pkg::result_t              result_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssa_pkg::PADDR_W-1:0]   paddr,
  input  logic [ssa_pkg::PDATA_W-1:0]   pwdata,
  output logic [ssa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_REPORT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  localparam int unsigned WB  = ssa_pkg::WORD_BITS;
  localparam int unsigned RW  = ssa_pkg::ROW_W;
  localparam int unsigned BW  = ssa_pkg::BIT_W;
  localparam int unsigned CW  = ssa_pkg::CFG_W;
  localparam int unsigned HW  = CW - BW;
  localparam int unsigned CNT_W_L = ssa_pkg::CNT_W;

  logic [2:0]                      state_q, state_d;
  logic [CW-1:0]                   slots_present_q;
  logic [1:0]                      op_q, op_d;
  logic [ssa_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic [ssa_pkg::SECTOR_W-1:0]    sector_q, sector_d;
  logic [ssa_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic [1:0]                      kind_q, kind_d;
  logic [1:0]                      status_q, status_d;
  logic [CNT_W_L-1:0]              cnt_q, cnt_d;
  logic [RW-1:0]                   word_q, word_d;
  logic [RW-1:0]                   rd_row_q;
  logic [ssa_pkg::ROWS-1:0]        row_valid_q;

  logic [CW-1:0]                   limit;
  logic [HW-1:0]                   lim_hi;
  logic [BW-1:0]                   lim_lo;
  logic [WB-1:0]                   limit_mask;
  logic [WB-1:0]                   rd_word;
  logic [WB-1:0]                   masked;
  logic [BW-1:0]                   first_bit;
  logic [HW-1:0]                   next_word;
  logic                            scan_more;
  logic [RW-1:0]                   idx_row;
  logic [BW-1:0]                   slot_bit;
  logic                            ram_re;
  logic [RW-1:0]                   ram_raddr;
  logic                            ram_we;
  logic [RW-1:0]                   ram_waddr;
  logic [WB-1:0]                   ram_wdata;
  logic [WB-1:0]                   ram_rdata;
  logic                            accept;
  logic                            cfg_write;
  logic                            emit_last;

  // Configuration register; the register index is the word address bit.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_present_q <= ssa_pkg::SLOTS_PRESENT_RESET;
    end else if (cfg_write && (paddr[2] == ssa_pkg::REG_SLOTS_PRESENT)) begin
      slots_present_q <= pwdata[CW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ssa_pkg::REG_SLOTS_PRESENT) begin
      prdata = ssa_pkg::PDATA_W'(slots_present_q);
    end
  end

  // Usable slot count and the mask of usable slots in the word being scanned.
  assign limit  = (slots_present_q > CW'(ssa_pkg::SLOTS)) ? CW'(ssa_pkg::SLOTS)
                                                          : slots_present_q;
  assign lim_hi = limit[CW-1:BW];
  assign lim_lo = limit[BW-1:0];

  always_comb begin
    if (HW'(word_q) < lim_hi) begin
      limit_mask = '1;
    end else if (HW'(word_q) == lim_hi) begin
      limit_mask = (WB'(1) << lim_lo) - WB'(1);
    end else begin
      limit_mask = '0;
    end
  end

  // Another word holds usable slots when it lies below the limit.
  assign next_word = HW'(word_q) + HW'(1);
  assign scan_more = (next_word < lim_hi) || ((next_word == lim_hi) && (lim_lo != '0));

  // Rows never written read as all free.
  assign rd_word   = row_valid_q[rd_row_q] ? ram_rdata : '1;
  assign masked    = rd_word & limit_mask;
  assign first_bit = ssa_pkg::lowest_set(masked);

  assign idx_row  = cmd_i.slot_index[ssa_pkg::SLOT_W-1:BW];
  assign slot_bit = slot_q[BW-1:0];

  assign accept    = start_i && !busy_o;
  assign busy_o    = (state_q != S_IDLE);
  assign emit_last = (cnt_q == CNT_W_L'(ssa_pkg::PAGE_SECTORS - 1));

  // Read address: prefetch the next word while scanning, else row 0 for a swap-out and the command's row otherwise.
  always_comb begin
    ram_re = 1'b1;
    if (state_q == S_SCAN) begin
      ram_raddr = word_q + RW'(1);
    end else if (cmd_i.opcode == ssa_pkg::OP_SWAP_OUT) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = idx_row;
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    slot_d    = slot_q;
    sector_d  = sector_q;
    addr_d    = addr_q;
    kind_d    = kind_q;
    status_d  = status_q;
    cnt_d     = cnt_q;
    word_d    = word_q;
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = rd_word;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = cmd_i.opcode;
          slot_d = cmd_i.slot_index;
          addr_d = ssa_pkg::ADDR_W'(cmd_i.frame_number)
                   * ssa_pkg::ADDR_W'(ssa_pkg::PAGE_BYTES);
          cnt_d  = '0;
          word_d = '0;
          if (cmd_i.opcode == ssa_pkg::OP_SWAP_OUT) begin
            state_d = S_SCAN;
          end else if ((cmd_i.opcode == ssa_pkg::OP_SWAP_IN) ||
                       (cmd_i.opcode == ssa_pkg::OP_FREE)) begin
            if (CW'(cmd_i.slot_index) >= limit) begin
              status_d = ssa_pkg::STAT_RANGE;
              state_d  = S_REPORT;
            end else begin
              state_d = S_CHECK;
            end
          end
        end
      end
      S_SCAN: begin
        if (masked != '0) begin
          // Lowest usable free slot found: mark it used.
          slot_d    = ssa_pkg::SLOT_W'({word_q, first_bit});
          sector_d  = ssa_pkg::SECTOR_W'({word_q, first_bit})
                      * ssa_pkg::SECTOR_W'(ssa_pkg::PAGE_SECTORS);
          kind_d    = ssa_pkg::KIND_WRITE;
          ram_we    = 1'b1;
          ram_waddr = word_q;
          ram_wdata = rd_word & ~(WB'(1) << first_bit);
          state_d   = S_EMIT;
        end else if (scan_more) begin
          word_d = word_q + RW'(1);
        end else begin
          slot_d   = '0;
          status_d = ssa_pkg::STAT_FULL;
          state_d  = S_REPORT;
        end
      end
      S_CHECK: begin
        if (rd_word[slot_bit]) begin
          status_d = ssa_pkg::STAT_UNUSED;
          state_d  = S_REPORT;
        end else begin
          // Release the slot; a swap-in then reads its sectors back.
          ram_we    = 1'b1;
          ram_waddr = slot_q[ssa_pkg::SLOT_W-1:BW];
          ram_wdata = rd_word | (WB'(1) << slot_bit);
          if (op_q == ssa_pkg::OP_SWAP_IN) begin
            sector_d = ssa_pkg::SECTOR_W'(slot_q)
                       * ssa_pkg::SECTOR_W'(ssa_pkg::PAGE_SECTORS);
            kind_d   = ssa_pkg::KIND_READ;
            state_d  = S_EMIT;
          end else begin
            status_d = ssa_pkg::STAT_OK;
            state_d  = S_REPORT;
          end
        end
      end
      S_REPORT: begin
        state_d = S_IDLE;
      end
      S_EMIT: begin
        sector_d = sector_q + ssa_pkg::SECTOR_W'(1);
        addr_d   = addr_q + ssa_pkg::ADDR_W'(ssa_pkg::SECTOR_BYTES);
        cnt_d    = cnt_q + CNT_W_L'(1);
        if (emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    slot_q   <= slot_d;
    sector_q <= sector_d;
    addr_q   <= addr_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    cnt_q    <= cnt_d;
    word_q   <= word_d;
    rd_row_q <= ram_raddr;
  end

  // Free map storage.
  ssa_ram #(
    .WIDTH (ssa_pkg::WORD_BITS),
    .DEPTH (ssa_pkg::ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result transfer.
  always_comb begin
    result_valid_o = 1'b0;
    result_o       = '0;
    result_o.slot_number = slot_q;
    if (state_q == S_EMIT) begin
      result_valid_o          = 1'b1;
      result_o.sector_number  = sector_q;
      result_o.memory_address = addr_q;
      result_o.command_kind   = kind_q;
      result_o.status         = ssa_pkg::STAT_OK;
      result_o.last           = emit_last;
    end else if (state_q == S_REPORT) begin
      result_valid_o        = 1'b1;
      result_o.command_kind = ssa_pkg::KIND_NONE;
      result_o.status       = status_q;
      result_o.last         = 1'b1;
    end
  end

  // Checks on the sequencer.
  `SSA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept && (cmd_i.opcode != ssa_pkg::OP_RESERVED), busy_o, "accepted command did not raise busy")
  `SSA_ASSERT_IMP(a_map_write_state, clk_i, rst_ni, ram_we, (state_q == S_SCAN) || (state_q == S_CHECK), "free map written outside scan or check")
  `SSA_ASSERT_IMP(a_none_zero, clk_i, rst_ni, result_valid_o && (result_o.command_kind == ssa_pkg::KIND_NONE), (result_o.sector_number == '0) && (result_o.memory_address == '0), "result without command carries sector or address")
  `SSA_ASSERT_IMP(a_error_last, clk_i, rst_ni, result_valid_o && (result_o.status != ssa_pkg::STAT_OK), result_o.last, "error result is not the last of its command")
  `SSA_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, result_valid_o && result_o.last, !busy_o, "block stayed busy after the last result")

endmodule

/* bench/ssa_result_checker.sv */
// Checker for the swap slot allocator: watches the command, result and register ports.
// It keeps its own free map and slot count, and compares each result transfer with the oldest
// owed one. Depends on ssa_pkg.
`timescale 1ns / 1ps

module ssa_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  ssa_pkg::cmd_t                 cmd_i,
  input  logic                          result_valid_i,
  input  ssa_pkg::result_t              result_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssa_pkg::PADDR_W-1:0]   paddr,
  input  logic [ssa_pkg::PDATA_W-1:0]   pwdata,
  input  logic [ssa_pkg::PDATA_W-1:0]   prdata,
  input  logic                          pready,
  output int                            owed_count_o,
  output int                            results_seen_o,
  output int                            fail_count_o
);
  import ssa_pkg::*;

  localparam int REPORT_MAX = 10;
  localparam logic [PADDR_W-1:0] SLOTS_PRESENT_ADDR = {REG_SLOTS_PRESENT, 2'b00};

  logic [SLOTS-1:0] free_map;
  logic [CFG_W-1:0] slots_present_q;
  result_t          owed_results[$];
  int               results_seen;
  int               fail_count;

  // Slots that a command may touch: the register value, capped at the map size.
  function automatic int unsigned usable_slots();
    return (slots_present_q > SLOTS) ? SLOTS : int'(slots_present_q);
  endfunction

  // A failure is always counted; only the first few are described.
  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
  endfunction

  // One result that carries no sector command.
  function automatic void owe_status(input logic [SLOT_W-1:0] slot, input logic [1:0] status);
    result_t r;
    r.slot_number    = slot;
    r.sector_number  = '0;
    r.memory_address = '0;
    r.command_kind   = KIND_NONE;
    r.status         = status;
    r.last           = 1'b1;
    owed_results.push_back(r);
  endfunction

  // One sector command per sector of the page, the last one flagged.
  function automatic void owe_sector_cmds(input logic [SLOT_W-1:0] slot,
                                          input logic [FRAME_W-1:0] frame,
                                          input logic [1:0] kind);
    result_t r;
    for (int i = 0; i < PAGE_SECTORS; i++) begin
      r.slot_number    = slot;
      r.sector_number  = SECTOR_W'(int'(slot) * PAGE_SECTORS + i);
      r.memory_address = ADDR_W'(64'(frame) * PAGE_BYTES + 64'(i) * SECTOR_BYTES);
      r.command_kind   = kind;
      r.status         = STAT_OK;
      r.last           = (i == PAGE_SECTORS - 1);
      owed_results.push_back(r);
    end
  endfunction

  // Update the free map for one accepted command and queue what it must produce.
  function automatic void allocate_and_predict(input cmd_t c);
    int unsigned limit;
    int          found;
    limit = usable_slots();
    found = -1;
    case (c.opcode)
      OP_SWAP_OUT: begin
        for (int s = 0; s < int'(limit); s++) begin
          if (free_map[s] && found < 0) begin
            found = s;
          end
        end
        if (found < 0) begin
          owe_status('0, STAT_FULL);
        end else begin
          free_map[found] = 1'b0;
          owe_sector_cmds(SLOT_W'(found), c.frame_number, KIND_WRITE);
        end
      end
      OP_SWAP_IN, OP_FREE: begin
        if (c.slot_index >= limit) begin
          owe_status(c.slot_index, STAT_RANGE);
        end else if (free_map[c.slot_index]) begin
          owe_status(c.slot_index, STAT_UNUSED);
        end else begin
          free_map[c.slot_index] = 1'b1;
          if (c.opcode == OP_SWAP_IN) begin
            owe_sector_cmds(c.slot_index, c.frame_number, KIND_READ);
          end else begin
            owe_status(c.slot_index, STAT_OK);
          end
        end
      end
      default: begin
        // The unused opcode leaves everything as it is.
      end
    endcase
  endfunction

  // Field-by-field comparison against the oldest owed result.
  function automatic void check_result(input result_t got);
    result_t want;
    if (owed_results.size() == 0) begin
      note_failure($sformatf("result with nothing owed: slot %0d sector %0d addr %h kind %0d status %0d last %0b",
                             got.slot_number, got.sector_number, got.memory_address,
                             got.command_kind, got.status, got.last));
      return;
    end
    want = owed_results.pop_front();
    if (got.slot_number !== want.slot_number || got.sector_number !== want.sector_number ||
        got.memory_address !== want.memory_address || got.command_kind !== want.command_kind ||
        got.status !== want.status || got.last !== want.last) begin
      note_failure($sformatf({"expected slot %0d sector %0d addr %h kind %0d status %0d last %0b,",
                              " got slot %0d sector %0d addr %h kind %0d status %0d last %0b"},
                             want.slot_number, want.sector_number, want.memory_address,
                             want.command_kind, want.status, want.last,
                             got.slot_number, got.sector_number, got.memory_address,
                             got.command_kind, got.status, got.last));
    end
  endfunction

  // Results are taken before commands, since a command never answers at the edge it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map        = '1;
      slots_present_q = SLOTS_PRESENT_RESET;
      owed_results.delete();
      results_seen    = 0;
      fail_count      = 0;
    end else begin
      if (result_valid_i) begin
        results_seen++;
        check_result(result_i);
      end
      if (start_i && !busy_i) begin
        allocate_and_predict(cmd_i);
      end
      if (psel && penable && pready && paddr == SLOTS_PRESENT_ADDR) begin
        if (pwrite) begin
          slots_present_q = pwdata[CFG_W-1:0];
        end else if (prdata !== PDATA_W'(slots_present_q)) begin
          note_failure($sformatf("register read expected %0d, got %0d", slots_present_q, prdata));
        end
      end
    end
    owed_count_o   <= owed_results.size();
    results_seen_o <= results_seen;
    fail_count_o   <= fail_count;
  end

endmodule

/* bench/testbench.sv */
// Top of the swap slot allocator bench: clock, reset, command and register stimulus, verdict.
// Depends on ssa_pkg, swap_slot_allocator_core and ssa_result_checker.
`timescale 1ns / 1ps

module testbench;
  import ssa_pkg::*;

  localparam int                 PHASE_ITEMS  = 55;
  localparam int                 DRAIN_CYCLES = 48;
  localparam logic [PADDR_W-1:0] SLOTS_PRESENT_ADDR = {REG_SLOTS_PRESENT, 2'b00};

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  cmd_t               cmd_i;
  logic               result_valid_o;
  result_t            result_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int owed_count;
  int results_seen;
  int fail_count;

  int          op_counts [4];
  int          settings_done;
  int unsigned slot_limit;
  int unsigned held_hint;
  bit          gaps_on;
  int unsigned slot_settings [8] = '{1024, 2047, 40, 0, 1, 100, 7, 1024};

  swap_slot_allocator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  ssa_result_checker u_result_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .cmd_i          (cmd_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .owed_count_o   (owed_count),
    .results_seen_o (results_seen),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or a result never arrives.
  initial begin
    #1600000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Hold start high until the block takes the command.
  task automatic send_cmd(input logic [1:0] op, input logic [SLOT_W-1:0] idx,
                          input logic [FRAME_W-1:0] frame);
    cmd_i   <= '{opcode: op, slot_index: idx, frame_number: frame};
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    op_counts[op]++;
  endtask

  task automatic idle_cycles(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait until every owed result has come and the block has settled.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (owed_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Write the slot count, then read it back for the checker.
  task automatic set_slots_present(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOTS_PRESENT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    slot_limit = (value > SLOTS) ? SLOTS : value;
    settings_done++;
  endtask

  // Mostly well-formed traffic: swap-ins and frees aim at the low slots that
  // swap-outs have most likely taken; a few go anywhere, a few are unused opcodes.
  task automatic random_command(output bit counted);
    int unsigned pick;
    int unsigned idx;
    logic [1:0]  op;
    pick    = $urandom_range(0, 99);
    idx     = $urandom_range(0, (held_hint < SLOTS) ? held_hint : SLOTS - 1);
    counted = 1'b1;
    if (pick < 40) begin
      op  = OP_SWAP_OUT;
      idx = $urandom_range(0, SLOTS - 1);
      if (held_hint < slot_limit) held_hint++;
    end else if (pick < 90) begin
      op = (pick < 65) ? OP_SWAP_IN : OP_FREE;
      if (held_hint > 0) held_hint--;
    end else if (pick < 95) begin
      op  = pick[0] ? OP_SWAP_IN : OP_FREE;
      idx = $urandom_range(0, SLOTS - 1);
    end else begin
      op      = OP_RESERVED;
      idx     = $urandom_range(0, SLOTS - 1);
      counted = 1'b0;
    end
    send_cmd(op, SLOT_W'(idx), FRAME_W'($urandom));
  endtask

  initial begin
    bit took;
    bit paused;
    int taken;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    cmd_i    = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    gaps_on  = 1'b1;
    held_hint  = 0;
    slot_limit = SLOTS;
    settings_done = 0;
    foreach (op_counts[i]) op_counts[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: both ends of the frame range, the ok and unused statuses, the unused opcode.
    send_cmd(OP_SWAP_OUT, 10'h3FF, 20'h00000);
    send_cmd(OP_SWAP_OUT, 10'h000, 20'hFFFFF);
    send_cmd(OP_SWAP_IN,  10'd0,   20'h12345);
    send_cmd(OP_SWAP_IN,  10'd0,   20'h00000);
    send_cmd(OP_FREE,     10'd1,   20'hFFFFF);
    send_cmd(OP_FREE,     10'd1,   20'h00000);
    send_cmd(OP_RESERVED, 10'h3FF, 20'hFFFFF);
    send_cmd(OP_SWAP_IN,  10'd1023, 20'hFFFFF);
    send_cmd(OP_FREE,     10'd1023, 20'h00000);
    wait_drained();

    // Two usable slots: fill the map, then hit the range check.
    set_slots_present(2);
    send_cmd(OP_SWAP_OUT, 10'd5,    20'hABCDE);
    send_cmd(OP_SWAP_OUT, 10'd0,    20'h54321);
    send_cmd(OP_SWAP_OUT, 10'd0,    20'h00001);
    send_cmd(OP_SWAP_IN,  10'd2,    20'h00000);
    send_cmd(OP_FREE,     10'd1023, 20'h00000);
    send_cmd(OP_FREE,     10'd1,    20'h00000);
    send_cmd(OP_SWAP_OUT, 10'd0,    20'h80000);
    wait_drained();

    // No usable slots at all.
    set_slots_present(0);
    send_cmd(OP_SWAP_OUT, 10'd0, 20'h7FFFF);
    send_cmd(OP_SWAP_IN,  10'd0, 20'h00000);
    wait_drained();

    // A count above the map size acts as the full map.
    set_slots_present(2047);
    send_cmd(OP_SWAP_IN, 10'd0, 20'hFEDCB);
    send_cmd(OP_FREE,    10'd1, 20'h00000);
    wait_drained();

    // Random phases, one per slot count; two of them run with no sender gaps.
    foreach (slot_settings[p]) begin
      set_slots_present(slot_settings[p]);
      gaps_on = (p != 2 && p != 3);
      paused  = 1'b0;
      taken   = 0;
      while (taken < PHASE_ITEMS) begin
        random_command(took);
        if (took) taken++;
        if (!paused && taken == PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_drained();
        end else if (gaps_on && $urandom_range(0, 99) < 25) begin
          idle_cycles($urandom_range(1, 45));
        end
      end
      wait_drained();
    end

    $display("Ran %0d swap-outs, %0d swap-ins, %0d frees and %0d unused opcodes under %0d slot counts.",
             op_counts[OP_SWAP_OUT], op_counts[OP_SWAP_IN], op_counts[OP_FREE],
             op_counts[OP_RESERVED], settings_done);
    $display("Checked %0d result transfers; %0d failures found.", results_seen, fail_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* swap_slot_allocator_core.f */
+incdir+rtl
rtl/ssa_pkg.sv
rtl/ssa_ram.sv
rtl/swap_slot_allocator_core.sv
bench/ssa_result_checker.sv
bench/testbench.sv
